FILE: rtl/core/can_bit_timing_search_defines.svh
// Assertion macros for the CAN bit timing search block.
// Used by the port-level checker; depends on nothing else.
`ifndef CAN_BIT_TIMING_SEARCH_DEFINES_SVH
`define CAN_BIT_TIMING_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CBTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbts: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CBTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbts: next-cycle check failed");

`endif

FILE: rtl/core/cbts_pkg.sv
// Shared types and constants for the CAN bit timing search block.
// No dependencies; used by the top level, the sequencer and the datapath.
`default_nettype none
package cbts_pkg;

   localparam int RATE_W      = 20;
   localparam int CLK_W       = 32;
   localparam int SPP_W       = 7;
   localparam int JW_W        = 3;
   localparam int PRE_CODE_W  = 10;
   localparam int SEG1_CODE_W = 4;
   localparam int SEG2_CODE_W = 3;
   localparam int JUMP_CODE_W = 2;
   localparam int DELTA_W     = 7;

   localparam int W_MIN = 3;
   localparam int PCT   = 100;

   // floor(x / 100) = (x * 5243) >> 19 for every x below 12320
   localparam int RECIP_100   = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_CLOCK_HZ     = 2'd0;
   localparam logic [1:0] REG_SAMPLE_POINT = 2'd1;
   localparam logic [1:0] REG_JUMP_WIDTH   = 2'd2;
   localparam logic [1:0] REG_EXACT_ONLY   = 2'd3;

   localparam logic [CLK_W-1:0] CLOCK_HZ_RST     = 32'd36000000;
   localparam logic [SPP_W-1:0] SAMPLE_POINT_RST = 7'd87;
   localparam logic [JW_W-1:0]  JUMP_WIDTH_RST   = 3'd1;

   typedef struct packed {
      logic [CLK_W-1:0] clock_hz;
      logic [SPP_W-1:0] sample_point_percent;
      logic [JW_W-1:0]  jump_width;
      logic             exact_only;
   } cfg_type;

   typedef struct packed {
      logic init;
      logic load;
      logic split;
      logic div_start;
      logic eval;
      logic advance;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rate_zero;
      logic too_big;
      logic div_done;
      logic stop;
      logic w_last;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/core/can_bit_timing_search.sv
// Top level of the CAN bit timing search: register bank, sequencer, datapath.
// Depends on cbts_pkg, cbts_ctrl and cbts_datapath.
`default_nettype none
// For each requested bit rate the block searches bit widths from
// SEG1_MAX + SEG2_MAX + 3 quanta down to 3 and returns the prescaler and
// segment codes of the best split for the programmed clock, sample point and
// sync jump width, or found = 0. One rate is worked on at a time; req_stall
// stays high after the accepting beat until the result is loaded into the
// output register, and the next rate is taken while that result still waits.
// Each width that passes the bit clock check goes through the bit clock and
// sample products, the reciprocal divide by 100, the launch of the dividers,
// 32 steps of the restoring divider that forms clock / bit clock and its
// remainder, a state in which the sequencer sees both dividers idle, and the
// judging of the candidate. A width whose bit clock exceeds the clock skips
// the dividers. A zero rate goes straight to the result, an exact match stops
// the search early, and a finished result waits while a stalled output
// register stays full. Registers sit at byte offsets 0x0 clock_hz, 0x4
// sample_point_percent, 0x8 jump_width, 0xC exact_only; write them only
// while no rate is in flight.
module can_bit_timing_search #(
   parameter int SEG1_MAX      = 15,
   parameter int SEG2_MAX      = 7,
   parameter int PRESCALER_MAX = 1023
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [cbts_pkg::CSR_AW-1:0]          csr_paddr,
   input  wire logic [cbts_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [cbts_pkg::CSR_DW-1:0]               csr_prdata,
   output logic                                      csr_pready,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [cbts_pkg::RATE_W-1:0]          req_rate_bps,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_found,
   output logic [cbts_pkg::PRE_CODE_W-1:0]           rsp_prescaler_code,
   output logic [cbts_pkg::SEG1_CODE_W-1:0]          rsp_seg1_code,
   output logic [cbts_pkg::SEG2_CODE_W-1:0]          rsp_seg2_code,
   output logic [cbts_pkg::JUMP_CODE_W-1:0]          rsp_jump_code
);

   cbts_pkg::cfg_type cfg_ff, cfg_in;
   cbts_pkg::cmd_type cmd;
   cbts_pkg::sts_type sts;
   logic              csr_write;
   logic [1:0]        csr_index;

   // The bus never waits
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // Write the addressed register, masked to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            cbts_pkg::REG_CLOCK_HZ:
               cfg_in.clock_hz = csr_pwdata;
            cbts_pkg::REG_SAMPLE_POINT:
               cfg_in.sample_point_percent = csr_pwdata[cbts_pkg::SPP_W-1:0];
            cbts_pkg::REG_JUMP_WIDTH:
               cfg_in.jump_width = csr_pwdata[cbts_pkg::JW_W-1:0];
            cbts_pkg::REG_EXACT_ONLY:
               cfg_in.exact_only = csr_pwdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_hz             <= cbts_pkg::CLOCK_HZ_RST;
         cfg_ff.sample_point_percent <= cbts_pkg::SAMPLE_POINT_RST;
         cfg_ff.jump_width           <= cbts_pkg::JUMP_WIDTH_RST;
         cfg_ff.exact_only           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         cbts_pkg::REG_CLOCK_HZ:
            csr_prdata = cfg_ff.clock_hz;
         cbts_pkg::REG_SAMPLE_POINT:
            csr_prdata = cbts_pkg::CSR_DW'(cfg_ff.sample_point_percent);
         cbts_pkg::REG_JUMP_WIDTH:
            csr_prdata = cbts_pkg::CSR_DW'(cfg_ff.jump_width);
         cbts_pkg::REG_EXACT_ONLY:
            csr_prdata = cbts_pkg::CSR_DW'(cfg_ff.exact_only);
         default:
            csr_prdata = '0;
      endcase
   end

   // Sequencer: accepts a rate, steps the width loop, hands over the result
   cbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: products, dividers, checks, best candidate and output register
   cbts_datapath #(
      .SEG1_MAX      (SEG1_MAX),
      .SEG2_MAX      (SEG2_MAX),
      .PRESCALER_MAX (PRESCALER_MAX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .cfg                (cfg_ff),
      .req_rate_bps       (req_rate_bps),
      .rsp_found          (rsp_found),
      .rsp_prescaler_code (rsp_prescaler_code),
      .rsp_seg1_code      (rsp_seg1_code),
      .rsp_seg2_code      (rsp_seg2_code),
      .rsp_jump_code      (rsp_jump_code)
   );

endmodule
`default_nettype wire

FILE: rtl/core/cbts_divider.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; no package dependency.
`default_nettype none
module cbts_divider #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  busy,
   output logic [WIDTH-1:0]      quotient,
   output logic [WIDTH-1:0]      remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [WIDTH:0]   trial;

   assign trial = {rem_ff, quo_ff[WIDTH-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = WIDTH'(trial - {1'b0, divisor});
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cbts_ctrl.sv
// Sequencer for the bit timing search: walks widths and drives the datapath.
// Depends on cbts_pkg for the command and status types.
`default_nettype none
module cbts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire cbts_pkg::sts_type sts,
   output cbts_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SPLIT,
      ST_START,
      ST_DIV,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.init = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (sts.rate_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.load = 1'b1;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = ST_START;
         end
         ST_START: begin
            if (!sts.too_big) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (sts.w_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.stop || sts.w_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_FINISH: begin
            // output register free, or emptied in this same cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cbts_datapath.sv
// Datapath of the bit timing search: width counter, products, two dividers,
// candidate checks and best-candidate store. Depends on cbts_pkg and cbts_divider.
`default_nettype none
module cbts_datapath #(
   parameter int SEG1_MAX      = 15,
   parameter int SEG2_MAX      = 7,
   parameter int PRESCALER_MAX = 1023
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cbts_pkg::cmd_type                     cmd,
   output cbts_pkg::sts_type                          sts,
   input  wire cbts_pkg::cfg_type                     cfg,
   input  wire logic [cbts_pkg::RATE_W-1:0]           req_rate_bps,
   output logic                                       rsp_found,
   output logic [cbts_pkg::PRE_CODE_W-1:0]            rsp_prescaler_code,
   output logic [cbts_pkg::SEG1_CODE_W-1:0]           rsp_seg1_code,
   output logic [cbts_pkg::SEG2_CODE_W-1:0]           rsp_seg2_code,
   output logic [cbts_pkg::JUMP_CODE_W-1:0]           rsp_jump_code
);

   localparam int W_MAX  = SEG1_MAX + SEG2_MAX + 3;
   localparam int WW     = $clog2(W_MAX + 1);
   localparam int PW     = WW + 1;
   localparam int BCW    = cbts_pkg::RATE_W + WW;
   localparam int PRODW  = WW + cbts_pkg::SPP_W;
   localparam int RPW    = PRODW + cbts_pkg::RECIP_W;
   localparam int SPW    = PW + 7;
   localparam int CLK_W  = cbts_pkg::CLK_W;
   localparam int DW     = cbts_pkg::DELTA_W;

   logic [cbts_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [WW-1:0]               w_ff, w_in;
   logic [BCW-1:0]              bitclk_ff, bitclk_in;
   logic [PRODW-1:0]            prod_ff, prod_in;
   logic [PW-1:0]               p_ff, p_in;

   logic                        have_ff, have_in;
   logic [CLK_W-1:0]            best_err_ff, best_err_in;
   logic [DW-1:0]               best_delta_ff, best_delta_in;
   logic [cbts_pkg::PRE_CODE_W-1:0]  best_pre_ff, best_pre_in;
   logic [cbts_pkg::SEG1_CODE_W-1:0] best_s1_ff, best_s1_in;
   logic [cbts_pkg::SEG2_CODE_W-1:0] best_s2_ff, best_s2_in;

   logic                              found_ff, found_in;
   logic [cbts_pkg::PRE_CODE_W-1:0]   pre_code_ff, pre_code_in;
   logic [cbts_pkg::SEG1_CODE_W-1:0]  s1_code_ff, s1_code_in;
   logic [cbts_pkg::SEG2_CODE_W-1:0]  s2_code_ff, s2_code_in;
   logic [cbts_pkg::JUMP_CODE_W-1:0]  jump_code_ff, jump_code_in;

   logic [RPW-1:0]   prod_recip;
   logic [CLK_W-1:0] big_quo, big_rem;
   logic [SPW-1:0]   sp_quo, sp_rem;
   logic             big_busy, sp_busy;
   logic [SPW-1:0]   sp_num;
   logic [SPW-1:0]   spp_x;
   logic [SPW-1:0]   delta_full;
   logic [DW-1:0]    delta;
   logic [PW-1:0]    s1, s2;
   logic             p_ok, seg_ok, err_ok, quo_ok, valid, keep;
   logic [cbts_pkg::JW_W-1:0] jw_m1;

   // Arithmetic for the current width
   assign prod_recip = RPW'(prod_ff) * RPW'(cbts_pkg::RECIP_100);
   assign sp_num     = SPW'(p_ff) * SPW'(cbts_pkg::PCT);

   cbts_divider #(.WIDTH(CLK_W)) u_clk_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cfg.clock_hz),
      .divisor   (CLK_W'(bitclk_ff)),
      .busy      (big_busy),
      .quotient  (big_quo),
      .remainder (big_rem)
   );

   cbts_divider #(.WIDTH(SPW)) u_sp_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (sp_num),
      .divisor   (SPW'(w_ff)),
      .busy      (sp_busy),
      .quotient  (sp_quo),
      .remainder (sp_rem)
   );

   // Candidate checks
   always_comb begin
      s1     = p_ff - PW'(1);
      s2     = PW'(w_ff) - p_ff;
      p_ok   = (p_ff != '0) && (p_ff < PW'(w_ff));
      seg_ok = (s1 <= PW'(SEG1_MAX + 1)) && (s2 <= PW'(SEG2_MAX + 1)) &&
               (s2 > PW'(cfg.jump_width)) &&
               ((PW + 1)'(s2) <= (PW + 1)'(s1) + (PW + 1)'(1));
      err_ok = (big_rem <= best_err_ff);
      quo_ok = (big_quo <= CLK_W'(PRESCALER_MAX + 1));
      valid  = err_ok && quo_ok && p_ok && seg_ok;
      spp_x  = SPW'(cfg.sample_point_percent);
      delta_full = (spp_x > sp_quo) ? (spp_x - sp_quo) : (sp_quo - spp_x);
      delta  = DW'(delta_full);
      keep   = valid && (!have_ff || (big_rem < best_err_ff) || (delta < best_delta_ff));
      jw_m1  = cfg.jump_width - cbts_pkg::JW_W'(1);
   end

   always_comb begin
      sts.rate_zero = (rate_ff == '0);
      sts.too_big   = (CLK_W'(bitclk_ff) > cfg.clock_hz);
      sts.div_done  = !big_busy && !sp_busy;
      sts.stop      = keep && (big_rem == '0) && (delta == '0);
      sts.w_last    = (w_ff == WW'(cbts_pkg::W_MIN));
   end

   // Next values
   always_comb begin
      rate_in       = rate_ff;
      w_in          = w_ff;
      bitclk_in     = bitclk_ff;
      prod_in       = prod_ff;
      p_in          = p_ff;
      have_in       = have_ff;
      best_err_in   = best_err_ff;
      best_delta_in = best_delta_ff;
      best_pre_in   = best_pre_ff;
      best_s1_in    = best_s1_ff;
      best_s2_in    = best_s2_ff;
      found_in      = found_ff;
      pre_code_in   = pre_code_ff;
      s1_code_in    = s1_code_ff;
      s2_code_in    = s2_code_ff;
      jump_code_in  = jump_code_ff;

      if (cmd.init) begin
         rate_in       = req_rate_bps;
         w_in          = WW'(W_MAX);
         have_in       = 1'b0;
         best_err_in   = cfg.exact_only ? '0 : '1;
         best_delta_in = '0;
      end
      if (cmd.load) begin
         bitclk_in = BCW'(rate_ff) * BCW'(w_ff);
         prod_in   = PRODW'(w_ff) * PRODW'(cfg.sample_point_percent);
      end
      if (cmd.split) begin
         p_in = PW'(prod_recip >> cbts_pkg::RECIP_SHIFT);
      end
      if (cmd.eval && keep) begin
         have_in       = 1'b1;
         best_err_in   = big_rem;
         best_delta_in = delta;
         best_pre_in   = big_quo[cbts_pkg::PRE_CODE_W-1:0] - cbts_pkg::PRE_CODE_W'(1);
         best_s1_in    = cbts_pkg::SEG1_CODE_W'(s1 - PW'(1));
         best_s2_in    = cbts_pkg::SEG2_CODE_W'(s2 - PW'(1));
      end
      if (cmd.advance) begin
         w_in = w_ff - WW'(1);
      end
      if (cmd.finish) begin
         // nothing found: every code reads zero
         found_in     = have_ff;
         pre_code_in  = have_ff ? best_pre_ff : '0;
         s1_code_in   = have_ff ? best_s1_ff : '0;
         s2_code_in   = have_ff ? best_s2_ff : '0;
         jump_code_in = have_ff ? jw_m1[cbts_pkg::JUMP_CODE_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff       <= rate_in;
      w_ff          <= w_in;
      bitclk_ff     <= bitclk_in;
      prod_ff       <= prod_in;
      p_ff          <= p_in;
      best_err_ff   <= best_err_in;
      best_delta_ff <= best_delta_in;
      best_pre_ff   <= best_pre_in;
      best_s1_ff    <= best_s1_in;
      best_s2_ff    <= best_s2_in;
      found_ff      <= found_in;
      pre_code_ff   <= pre_code_in;
      s1_code_ff    <= s1_code_in;
      s2_code_ff    <= s2_code_in;
      jump_code_ff  <= jump_code_in;
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   assign rsp_found          = found_ff;
   assign rsp_prescaler_code = pre_code_ff;
   assign rsp_seg1_code      = s1_code_ff;
   assign rsp_seg2_code      = s2_code_ff;
   assign rsp_jump_code      = jump_code_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cbts_checker.sv
// Port-level checks for the CAN bit timing search, bound to the top level.
// Depends on can_bit_timing_search_defines.svh for the assertion macros.
`default_nettype none
`include "can_bit_timing_search_defines.svh"
module cbts_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_found,
   input wire logic [9:0] rsp_prescaler_code,
   input wire logic [3:0] rsp_seg1_code,
   input wire logic [2:0] rsp_seg2_code,
   input wire logic [1:0] rsp_jump_code
);

   // A stalled result beat holds
   `CBTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_prescaler_code) && $stable(rsp_seg1_code) && $stable(rsp_seg2_code) && $stable(rsp_jump_code))

   // No timing found: every code is zero
   `CBTS_ASSERT_NOW(a_not_found_zero, clock, reset, rsp_valid && !rsp_found, (rsp_prescaler_code == 10'd0) && (rsp_seg1_code == 4'd0) && (rsp_seg2_code == 3'd0) && (rsp_jump_code == 2'd0))

   // One rate at a time: an accepted beat closes the request side
   `CBTS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // No result straight out of reset
   `CBTS_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind can_bit_timing_search cbts_checker u_checker (.*);
`default_nettype wire
